// ----- rtl/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg: shared types, constants and helpers
// Payload structs, sequencer codes and small bit helpers for the
// transformation-based Toffoli synthesizer.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int MAX_LINES = 8;
  localparam int TBL_DEPTH = 1 << MAX_LINES;
  localparam int ADDR_W    = MAX_LINES;
  localparam int ROW_W     = MAX_LINES + 1;
  localparam int DATA_W    = 8;

  // Operation codes of the input item
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_GATE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_BIDIR = 1'b0;
  localparam logic CFG_LINES = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] row_index;
    logic [7:0] row_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] control_mask;
    logic [2:0] tgt_line;
    logic       on_input_side;
    logic       done_res;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NOTS,
    PH_SCAN,
    PH_ADJUST,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_WT,
    S_DISPATCH,
    S_SCAN_CHK,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SWEEP_RD,
    S_SWEEP_WR,
    S_SWAP_RDX,
    S_SWAP_RDY,
    S_SWAP_WRX,
    S_SWAP_WRY,
    S_EMIT
  } seq_state_t;

  // Position of the lowest set bit (zero for an empty word)
  function automatic logic [2:0] low_bit_pos(input logic [7:0] v);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) p = 3'(i);
    end
    return p;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage

// ----- rtl/reversible_toffoli_synthesizer.sv -----
// ----------------------------------------------------------------------------
// reversible_toffoli_synthesizer: transformation-based Toffoli synthesis
// Holds a permutation table and emits one Toffoli gate or the done mark per request.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake         payload
//  in       into       in_valid/in_stall  in_data   (op, row_index, row_value)
//  out      out of     out_valid/out_stall out_data (gate or done mark)
//  cfg      into       cfg_we            cfg_index, cfg_data
//
// A load transfer writes one table row. A gate request scans rows, searches
// the partner row (bidirectional mode), then sweeps the table once through
// the single RAM port pair: a read and a write per row on the output side,
// two reads and two writes per swapped pair on the input side.
// Reset clears control state and the run; the table holds nothing valid
// until loaded. A stalled result waits in the output register while the
// next request is already taken.
module reversible_toffoli_synthesizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tts_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tts_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data
);
  import tts_pkg::*;

  logic       bidir;
  logic [3:0] line_count;
  logic       busy;
  logic       emit;
  out_item_t  res;
  logic       out_free;
  logic       ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bidir      <= 1'b1;
      line_count <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIDIR: bidir      <= cfg_data[0];
        CFG_LINES: line_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register: free when empty or when its result transfers now
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= res;
    end
  end

  // Accept only while the sequencer waits for work
  assign in_stall = busy;

  tts_ram #(
    .WIDTH(DATA_W),
    .DEPTH(TBL_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  tts_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .bidir     (bidir),
    .line_count(line_count),
    .out_free  (out_free),
    .busy      (busy),
    .emit      (emit),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

// ----- rtl/tts_ram.sv -----
// ----------------------------------------------------------------------------
// tts_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/tts_seq.sv -----
// ----------------------------------------------------------------------------
// tts_seq: synthesis sequencer
// Walks the algorithm phases, scans and searches the table and sweeps it
// once per gate through the shared RAM port pair.
// ----------------------------------------------------------------------------
module tts_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  tts_pkg::in_item_t        in_data,
  input  logic                     bidir,
  input  logic [3:0]               line_count,
  input  logic                     out_free,
  output logic                     busy,
  output logic                     emit,
  output tts_pkg::out_item_t       res,
  output logic                     ram_we,
  output logic [tts_pkg::ADDR_W-1:0] ram_waddr,
  output logic [tts_pkg::DATA_W-1:0] ram_wdata,
  output logic [tts_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [tts_pkg::DATA_W-1:0] ram_rdata
);
  import tts_pkg::*;

  seq_state_t state, state_next;
  phase_t     phase, phase_next;
  logic [ROW_W-1:0] cur_row, cur_row_next;
  logic [ROW_W-1:0] idx, idx_next;
  logic             use_front, use_front_next;
  logic [7:0]       run_mask, run_mask_next;
  logic [7:0]       pend_set, pend_set_next;
  logic [7:0]       pend_clr, pend_clr_next;
  logic [7:0]       row_val, row_val_next;
  logic [7:0]       gate_ctrl, gate_ctrl_next;
  logic [7:0]       gate_tbit, gate_tbit_next;
  logic [7:0]       swap_tmp, swap_tmp_next;
  out_item_t        res_next;

  logic [3:0]       lines;
  logic [ROW_W-1:0] nrows;
  logic [7:0]       m;

  always_comb begin
    if (line_count == 4'd0) begin
      lines = 4'd1;
    end else if (line_count > 4'(MAX_LINES)) begin
      lines = 4'(MAX_LINES);
    end else begin
      lines = line_count;
    end
    nrows = ROW_W'(1) << lines;
    m     = 8'(nrows - ROW_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_IDLE;
      cur_row   <= '0;
      use_front <= 1'b0;
      run_mask  <= '0;
      pend_set  <= '0;
      pend_clr  <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      cur_row   <= cur_row_next;
      use_front <= use_front_next;
      run_mask  <= run_mask_next;
      pend_set  <= pend_set_next;
      pend_clr  <= pend_clr_next;
    end
    idx       <= idx_next;
    row_val   <= row_val_next;
    gate_ctrl <= gate_ctrl_next;
    gate_tbit <= gate_tbit_next;
    swap_tmp  <= swap_tmp_next;
    res       <= res_next;
  end

  always_comb begin
    logic [7:0] v;
    logic [7:0] r8;
    logic [7:0] sel;
    logic [2:0] b;
    logic [7:0] t;
    logic [7:0] ctrl;
    logic [7:0] nm;
    logic [7:0] ns;
    logic [7:0] nc;
    logic [7:0] x8;
    logic       fin;
    logic       fin_front;

    state_next     = state;
    phase_next     = phase;
    cur_row_next   = cur_row;
    idx_next       = idx;
    use_front_next = use_front;
    run_mask_next  = run_mask;
    pend_set_next  = pend_set;
    pend_clr_next  = pend_clr;
    row_val_next   = row_val;
    gate_ctrl_next = gate_ctrl;
    gate_tbit_next = gate_tbit;
    swap_tmp_next  = swap_tmp;
    res_next       = res;
    ram_we         = 1'b0;
    ram_waddr      = idx[ADDR_W-1:0];
    ram_wdata      = '0;
    ram_raddr      = idx[ADDR_W-1:0];
    emit           = 1'b0;
    busy           = (state != S_IDLE);

    v         = ram_rdata & m;
    r8        = cur_row[7:0];
    x8        = idx[7:0];
    sel       = '0;
    b         = '0;
    t         = '0;
    ctrl      = '0;
    nm        = '0;
    ns        = '0;
    nc        = '0;
    fin       = 1'b0;
    fin_front = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_LOAD) begin
            // Store the row and restart the run from the table as it stands
            ram_we         = 1'b1;
            ram_waddr      = in_data.row_index;
            ram_wdata      = in_data.row_value;
            phase_next     = PH_IDLE;
            cur_row_next   = '0;
            use_front_next = 1'b0;
            run_mask_next  = '0;
            pend_set_next  = '0;
            pend_clr_next  = '0;
          end else begin
            state_next = S_DISPATCH;
          end
        end
      end

      S_START_WT: begin
        pend_set_next = v;
        cur_row_next  = ROW_W'(1);
        phase_next    = PH_NOTS;
        state_next    = S_DISPATCH;
      end

      S_DISPATCH: begin
        case (phase)
          PH_IDLE: begin
            if (!bidir) begin
              ram_raddr  = '0;
              state_next = S_START_WT;
            end else begin
              cur_row_next = '0;
              phase_next   = PH_SCAN;
            end
          end
          PH_NOTS: begin
            if ((pend_set & m) == 8'd0) begin
              pend_set_next = '0;
              phase_next    = PH_SCAN;
            end else begin
              b = low_bit_pos(pend_set & m);
              t = 8'd1 << b;
              pend_set_next          = pend_set & ~t;
              gate_ctrl_next         = '0;
              gate_tbit_next         = t;
              res_next.control_mask  = '0;
              res_next.tgt_line      = 3'(lines - 4'd1 - {1'b0, b});
              res_next.on_input_side = 1'b0;
              res_next.done_res      = 1'b0;
              idx_next               = '0;
              state_next             = S_SWEEP_RD;
            end
          end
          PH_SCAN: begin
            if (cur_row >= nrows) begin
              cur_row_next = nrows;
              phase_next   = PH_DONE;
            end else begin
              ram_raddr  = cur_row[ADDR_W-1:0];
              state_next = S_SCAN_CHK;
            end
          end
          PH_ADJUST: begin
            if ((pend_set & m) != 8'd0) begin
              b    = low_bit_pos(pend_set & m);
              t    = 8'd1 << b;
              ctrl = run_mask & m;
              nm   = (run_mask | t) & m;
              ns   = pend_set & ~t;
              nc   = pend_clr;
            end else if ((pend_clr & m) != 8'd0) begin
              b    = low_bit_pos(pend_clr & m);
              t    = 8'd1 << b;
              nm   = run_mask & ~t & m;
              ctrl = nm;
              ns   = pend_set;
              nc   = pend_clr & ~t;
            end
            if (t == 8'd0) begin
              pend_set_next = '0;
              pend_clr_next = '0;
              cur_row_next  = cur_row + ROW_W'(1);
              phase_next    = PH_SCAN;
            end else begin
              run_mask_next          = nm;
              pend_set_next          = ns;
              pend_clr_next          = nc;
              gate_ctrl_next         = ctrl;
              gate_tbit_next         = t;
              res_next.control_mask  = ctrl;
              res_next.tgt_line      = 3'(lines - 4'd1 - {1'b0, b});
              res_next.on_input_side = use_front;
              res_next.done_res      = 1'b0;
              idx_next               = '0;
              if ((ns & m) == 8'd0 && (nc & m) == 8'd0) begin
                pend_set_next = '0;
                pend_clr_next = '0;
                cur_row_next  = cur_row + ROW_W'(1);
                phase_next    = PH_SCAN;
              end
              state_next = use_front ? S_SWAP_RDX : S_SWEEP_RD;
            end
          end
          default: begin
            phase_next = PH_DONE;
            res_next   = '{control_mask: 8'd0, tgt_line: 3'd0,
                           on_input_side: 1'b0, done_res: 1'b1};
            state_next = S_EMIT;
          end
        endcase
      end

      S_SCAN_CHK: begin
        if (v == r8) begin
          cur_row_next = cur_row + ROW_W'(1);
          state_next   = S_DISPATCH;
        end else begin
          row_val_next = v;
          if (bidir) begin
            idx_next   = '0;
            state_next = S_SRCH_RD;
          end else begin
            fin = 1'b1;
          end
        end
      end

      S_SRCH_RD: begin
        if (idx >= nrows) begin
          fin = 1'b1;
        end else begin
          ram_raddr  = idx[ADDR_W-1:0];
          state_next = S_SRCH_CHK;
        end
      end

      S_SRCH_CHK: begin
        if (v == r8) begin
          fin       = 1'b1;
          fin_front = (pop8(x8 ^ r8) < pop8(r8 ^ row_val));
        end else begin
          idx_next   = idx + ROW_W'(1);
          state_next = S_SRCH_RD;
        end
      end

      S_SWEEP_RD: begin
        if (idx >= nrows) begin
          state_next = S_EMIT;
        end else begin
          ram_raddr  = idx[ADDR_W-1:0];
          state_next = S_SWEEP_WR;
        end
      end

      S_SWEEP_WR: begin
        // Flip the target bit of every output that covers the controls
        if ((v & gate_ctrl) == gate_ctrl) begin
          ram_we    = 1'b1;
          ram_wdata = v ^ gate_tbit;
        end
        idx_next   = idx + ROW_W'(1);
        state_next = S_SWEEP_RD;
      end

      S_SWAP_RDX: begin
        if (idx >= nrows) begin
          state_next = S_EMIT;
        end else if ((x8 & gate_ctrl) == gate_ctrl && (x8 & gate_tbit) == 8'd0) begin
          ram_raddr  = idx[ADDR_W-1:0];
          state_next = S_SWAP_RDY;
        end else begin
          idx_next = idx + ROW_W'(1);
        end
      end

      S_SWAP_RDY: begin
        swap_tmp_next = ram_rdata;
        ram_raddr     = x8 | gate_tbit;
        state_next    = S_SWAP_WRX;
      end

      S_SWAP_WRX: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        state_next = S_SWAP_WRY;
      end

      S_SWAP_WRY: begin
        ram_we     = 1'b1;
        ram_waddr  = x8 | gate_tbit;
        ram_wdata  = swap_tmp;
        idx_next   = idx + ROW_W'(1);
        state_next = S_SWAP_RDX;
      end

      S_EMIT: begin
        // Hold until the output register can take the result
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // The output value of the row may be captured in this same cycle
    if (fin) begin
      sel = fin_front ? x8 : row_val_next;
      use_front_next = fin_front;
      run_mask_next  = sel;
      pend_set_next  = r8 & ~sel & m;
      pend_clr_next  = sel & ~r8 & m;
      phase_next     = PH_ADJUST;
      state_next     = S_DISPATCH;
    end
  end

endmodule
